>>> src/wsrx_pkg.sv
// Shared types, codes and constants for the WebSocket receive deframer.
// No dependencies; imported by every module of the block.
package wsrx_pkg;

  localparam int LENGTH_BITS = 64;
  localparam int STATUS_LEN  = 12;

  // link phases
  localparam logic [1:0] PH_STATUS  = 2'd0;
  localparam logic [1:0] PH_HEADERS = 2'd1;
  localparam logic [1:0] PH_OPEN    = 2'd2;

  // result kinds
  localparam logic [1:0] EV_TEXT      = 2'd0;
  localparam logic [1:0] EV_PING      = 2'd1;
  localparam logic [1:0] EV_HS_ERROR  = 2'd2;
  localparam logic [1:0] EV_UNHANDLED = 2'd3;

  // frame opcodes
  localparam logic [3:0] OP_TEXT = 4'd1;
  localparam logic [3:0] OP_PING = 4'd9;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] HDR_END_16  = 4'd4;
  localparam logic [3:0] HDR_END_64  = 4'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] op;
    logic       first;
    logic       last;
    logic       empty;
  } res_t;

  // expected status line prefix "HTTP/1.1 101"
  function automatic logic [7:0] status_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "H";
      4'd1:    c = "T";
      4'd2:    c = "T";
      4'd3:    c = "P";
      4'd4:    c = "/";
      4'd5:    c = "1";
      4'd6:    c = ".";
      4'd7:    c = "1";
      4'd8:    c = " ";
      4'd9:    c = "1";
      4'd10:   c = "0";
      4'd11:   c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> src/wsrx_step.sv
// Per-byte state machine: handshake check and frame deframing.
// Depends on wsrx_pkg. Updates state and forms at most one result per byte.
module wsrx_step import wsrx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] b,
  output logic       res_valid,
  output res_t       res
);

  localparam int LEN_W = LENGTH_BITS;

  logic [1:0]       link_phase, link_phase_next;
  logic [3:0]       match_pos, match_pos_next;
  logic             match_good, match_good_next;
  logic             line_empty, line_empty_next;
  logic             saw_cr, saw_cr_next;
  logic [3:0]       hdr_pos, hdr_pos_next;
  logic [3:0]       cur_op, cur_op_next;
  logic [6:0]       len_code, len_code_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic             started, started_next;

  logic             handled;
  logic             line_end;
  logic [3:0]       hdr_pos_inc;
  logic [3:0]       hdr_need;

  assign handled     = (cur_op == OP_TEXT) || (cur_op == OP_PING);
  assign line_end    = saw_cr && (b == CHAR_LF);
  assign hdr_pos_inc = hdr_pos + 4'd1;
  assign hdr_need    = (len_code == LEN_CODE_16) ? HDR_END_16 : HDR_END_64;

  always_comb begin
    link_phase_next = link_phase;
    match_pos_next  = match_pos;
    match_good_next = match_good;
    line_empty_next = line_empty;
    saw_cr_next     = saw_cr;
    hdr_pos_next    = hdr_pos;
    cur_op_next     = cur_op;
    len_code_next   = len_code;
    remaining_next  = remaining;
    started_next    = started;
    res_valid       = 1'b0;
    res             = '0;

    case (link_phase)
      PH_OPEN: begin
        if (hdr_pos == 4'd0 && remaining != '0) begin
          remaining_next = remaining - {{(LEN_W-1){1'b0}}, 1'b1};
          started_next   = (remaining != {{(LEN_W-1){1'b0}}, 1'b1});
          if (handled) begin
            res_valid  = 1'b1;
            res.kind   = (cur_op == OP_PING) ? EV_PING : EV_TEXT;
            res.data   = b;
            res.op     = cur_op;
            res.first  = !started;
            res.last   = (remaining == {{(LEN_W-1){1'b0}}, 1'b1});
          end
        end else begin
          logic done;
          done = 1'b0;
          if (hdr_pos == 4'd0) begin
            cur_op_next  = b[3:0];
            hdr_pos_next = 4'd1;
          end else if (hdr_pos == 4'd1) begin
            len_code_next = b[6:0];
            if (b[6:0] < LEN_CODE_16) begin
              remaining_next = {{(LEN_W-7){1'b0}}, b[6:0]};
              done = 1'b1;
            end else begin
              remaining_next = '0;
              hdr_pos_next   = 4'd2;
            end
          end else begin
            // saturate once any of the top byte is set
            if (|remaining[LEN_W-1 -: 8]) begin
              remaining_next = '1;
            end else begin
              remaining_next = {remaining[LEN_W-9:0], b};
            end
            hdr_pos_next = hdr_pos_inc;
            done = (hdr_pos_inc >= hdr_need);
          end
          if (done) begin
            hdr_pos_next = 4'd0;
            started_next = 1'b0;
            if (!handled) begin
              res_valid = 1'b1;
              res.kind  = EV_UNHANDLED;
              res.op    = cur_op;
              res.last  = 1'b1;
            end else if (remaining_next == '0) begin
              res_valid = 1'b1;
              res.kind  = (cur_op == OP_PING) ? EV_PING : EV_TEXT;
              res.op    = cur_op;
              res.first = 1'b1;
              res.last  = 1'b1;
              res.empty = 1'b1;
            end
          end
        end
      end
      PH_HEADERS: begin
        if (line_end) begin
          if (line_empty) link_phase_next = PH_OPEN;
          line_empty_next = 1'b1;
          saw_cr_next     = 1'b0;
        end else begin
          if (saw_cr || b != CHAR_CR) line_empty_next = 1'b0;
          saw_cr_next = (b == CHAR_CR);
        end
      end
      default: begin
        // awaiting status line; unused phase code lands here too
        if (line_end) begin
          match_pos_next  = 4'd0;
          match_good_next = 1'b1;
          line_empty_next = 1'b1;
          saw_cr_next     = 1'b0;
          if (match_good && match_pos >= 4'(STATUS_LEN)) begin
            link_phase_next = PH_HEADERS;
          end else begin
            link_phase_next = PH_STATUS;
            res_valid       = 1'b1;
            res.kind        = EV_HS_ERROR;
            res.last        = 1'b1;
          end
        end else begin
          if (match_pos < 4'(STATUS_LEN)) begin
            if (b != status_char(match_pos)) match_good_next = 1'b0;
            match_pos_next = match_pos + 4'd1;
          end
          saw_cr_next = (b == CHAR_CR);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase <= PH_STATUS;
      match_pos  <= 4'd0;
      match_good <= 1'b1;
      line_empty <= 1'b1;
      saw_cr     <= 1'b0;
      hdr_pos    <= 4'd0;
      cur_op     <= 4'd0;
      len_code   <= 7'd0;
      remaining  <= '0;
      started    <= 1'b0;
    end else if (fire) begin
      link_phase <= link_phase_next;
      match_pos  <= match_pos_next;
      match_good <= match_good_next;
      line_empty <= line_empty_next;
      saw_cr     <= saw_cr_next;
      hdr_pos    <= hdr_pos_next;
      cur_op     <= cur_op_next;
      len_code   <= len_code_next;
      remaining  <= remaining_next;
      started    <= started_next;
    end
  end

endmodule

>>> src/wsrx_out_reg.sv
// Result register for the output channel.
// Depends on wsrx_pkg. Holds one result until the transfer completes.
module wsrx_out_reg import wsrx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t load_res,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic held, held_next;

  assign can_load  = !held || out_ready;
  assign out_valid = held;

  always_comb begin
    held_next = held;
    if (load) begin
      held_next = 1'b1;
    end else if (out_ready) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= load_res;
  end

endmodule

>>> src/websocket_client_rx_deframer_unit.sv
// WebSocket client receive deframer: handshake check, then frame parsing.
// Path: each byte transfers into the input register, then passes through the
// step logic into the result register once that register can load.
// Throughput: one byte per cycle; the input register drains into the step
// logic whenever the result register is empty or being taken.
// Reset (rst, synchronous): awaits the status line, no result held.
module websocket_client_rx_deframer_unit import wsrx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] data_byte,
  output logic [3:0] frame_op,
  output logic       first_of_payload,
  output logic       last_of_payload,
  output logic       empty_payload
);

  logic       in_held;
  logic [7:0] in_byte;
  logic       can_load;
  logic       fire;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign fire     = in_held && can_load;
  assign in_ready = !in_held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= rx_byte;
  end

  wsrx_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .b         (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsrx_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign event_kind       = out_res.kind;
  assign data_byte        = out_res.data;
  assign frame_op         = out_res.op;
  assign first_of_payload = out_res.first;
  assign last_of_payload  = out_res.last;
  assign empty_payload    = out_res.empty;

endmodule

>>> src/wsrx_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// Depends on wsrx_pkg and websocket_client_rx_deframer_unit.
module wsrx_checker import wsrx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [7:0] data_byte,
  input logic [3:0] frame_op,
  input logic       first_of_payload,
  input logic       last_of_payload,
  input logic       empty_payload
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(data_byte)
      && $stable(frame_op) && $stable(last_of_payload))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_payload |-> first_of_payload && last_of_payload
      && data_byte == 8'h00 && (event_kind == EV_TEXT || event_kind == EV_PING))
    else $error("empty payload result malformed");

  a_hs_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_HS_ERROR |-> frame_op == 4'd0 && !first_of_payload
      && last_of_payload && !empty_payload && data_byte == 8'h00)
    else $error("handshake error result malformed");

  a_unhandled: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_UNHANDLED |-> !first_of_payload && last_of_payload
      && !empty_payload && data_byte == 8'h00 && frame_op != OP_TEXT
      && frame_op != OP_PING)
    else $error("unhandled opcode result malformed");

endmodule

bind websocket_client_rx_deframer_unit wsrx_checker u_wsrx_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .event_kind       (event_kind),
  .data_byte        (data_byte),
  .frame_op         (frame_op),
  .first_of_payload (first_of_payload),
  .last_of_payload  (last_of_payload),
  .empty_payload    (empty_payload)
);
